[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files of the glyph converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ptag_pkg.sv]
// Shared types, constants and lookup functions of the pixel to glyph converter.
`default_nettype none

package ptag_pkg;

    localparam int MAX_LINE_WIDTH = 4096;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W           = COL_W + 1;
    localparam int QDEPTH         = 8;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);
    localparam int RAMP_LEN       = 10;
    localparam int IDX_W          = 4;
    localparam int CH_W           = 8;
    localparam int GLYPH_W        = 7;
    localparam int SQ_W           = 16;
    localparam int SUM_W          = 26;
    localparam int PROD_W         = 42;
    localparam int LHS_W          = 46;

    localparam logic [GLYPH_W-1:0] NEWLINE_CODE = 7'd10;
    localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'hFF;

    // 65025 * 2551^2: one luminance step, squared and scaled to integers.
    localparam logic [LHS_W-1:0] UNIT = 46'd423156755025;

    typedef enum logic [1:0] {
        REG_INVERT     = 2'd0,
        REG_LINE_WIDTH = 2'd1,
        REG_USE_ALPHA  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic            invert;
        logic [LW_W-1:0] line_width;
        logic            use_alpha;
    } cfg_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               row_end;
    } qentry_t;

    typedef enum logic {
        BK_GLYPH,
        BK_NEWLINE
    } bk_state_t;

    // Ramp from dense to sparse: "@%#*+=-:. "
    function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [IDX_W-1:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            4'd0:    g = 7'd64;
            4'd1:    g = 7'd37;
            4'd2:    g = 7'd35;
            4'd3:    g = 7'd42;
            4'd4:    g = 7'd43;
            4'd5:    g = 7'd61;
            4'd6:    g = 7'd45;
            4'd7:    g = 7'd58;
            4'd8:    g = 7'd46;
            default: g = 7'd32;
        endcase
        return g;
    endfunction

    // Threshold for ramp step k: UNIT * k^2.
    function automatic logic [LHS_W-1:0] thresh(input logic [IDX_W-1:0] k);
        return UNIT * LHS_W'(k) * LHS_W'(k);
    endfunction

endpackage

`default_nettype wire

[hdl/ptag_fifo.sv]
// Short queue of classified pixels between the front and back parts.
`default_nettype none
`include "assert_macros.svh"

module ptag_fifo
    import ptag_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_push,
    input  wire qentry_t q_entry,
    input  wire logic    q_pop,
    output qentry_t      q_head,
    output logic         q_empty
);

    qentry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(q_push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem_reg[wr_ptr_reg] <= q_entry;
        end
    end

    assign q_head  = mem_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);

    `CHK_NOW(a_no_overflow, clk, rst_n, q_push, count_reg != QCNT_W'(QDEPTH) || q_pop, "queue written while full")
    `CHK_NOW(a_no_underflow, clk, rst_n, q_pop, count_reg != '0, "queue read while empty")

endmodule

`default_nettype wire

[hdl/ptag_front.sv]
// Front part: accepts pixels, tracks the row position and computes the glyph.
`default_nettype none
`include "assert_macros.svh"

module ptag_front
    import ptag_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [CH_W-1:0] red,
    input  wire logic [CH_W-1:0] green,
    input  wire logic [CH_W-1:0] blue,
    input  wire logic [CH_W-1:0] alpha,
    input  wire logic            q_pop,
    output logic                 q_push,
    output qentry_t              q_entry
);

    logic              accept;
    logic [CH_W-1:0]   alpha_eff;
    logic [LW_W-1:0]   width_eff;
    logic [LW_W-1:0]   col_plus;
    logic              row_end;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [QCNT_W-1:0] credit_reg, credit_next;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [SQ_W-1:0]   s1_r2_reg, s1_g2_reg, s1_b2_reg, s1_a2_reg;
    logic              s1_row_end_reg, s2_row_end_reg, s3_row_end_reg;
    logic [SUM_W-1:0]  s2_sum_reg, s2_sum_next;
    logic [SQ_W-1:0]   s2_a2_reg;
    logic [PROD_W-1:0] s3_prod_reg, s3_prod_next;

    logic [LHS_W-1:0]  lhs;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  idx_sel;

    assign accept    = push && !full;
    assign full      = (credit_reg == QCNT_W'(QDEPTH));
    assign alpha_eff = cfg.use_alpha ? alpha : ALPHA_OPAQUE;

    // Row position; the width is clamped into 1..MAX_LINE_WIDTH.
    always_comb
    begin
        if (cfg.line_width == '0)
        begin
            width_eff = LW_W'(1);
        end
        else if (cfg.line_width > LW_W'(MAX_LINE_WIDTH))
        begin
            width_eff = LW_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            width_eff = cfg.line_width;
        end
        col_plus = {1'b0, col_reg} + LW_W'(1);
        row_end  = (col_plus >= width_eff);
        col_next = col_reg;
        if (accept)
        begin
            col_next = row_end ? '0 : col_plus[COL_W-1:0];
        end
        credit_next = credit_reg + QCNT_W'(accept) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Weighted sum of squares, then the product with alpha squared.
    assign s2_sum_next = SUM_W'(299) * SUM_W'(s1_r2_reg)
                       + SUM_W'(587) * SUM_W'(s1_g2_reg)
                       + SUM_W'(114) * SUM_W'(s1_b2_reg);
    assign s3_prod_next = s2_sum_reg * s2_a2_reg;

    always_ff @(posedge clk)
    begin
        s1_r2_reg      <= SQ_W'(red) * SQ_W'(red);
        s1_g2_reg      <= SQ_W'(green) * SQ_W'(green);
        s1_b2_reg      <= SQ_W'(blue) * SQ_W'(blue);
        s1_a2_reg      <= SQ_W'(alpha_eff) * SQ_W'(alpha_eff);
        s1_row_end_reg <= row_end;
        s2_sum_reg     <= s2_sum_next;
        s2_a2_reg      <= s1_a2_reg;
        s2_row_end_reg <= s1_row_end_reg;
        s3_prod_reg    <= s3_prod_next;
        s3_row_end_reg <= s2_row_end_reg;
    end

    // Ten times the product against the nine step thresholds.
    always_comb
    begin
        lhs = LHS_W'({s3_prod_reg, 3'b000}) + LHS_W'({s3_prod_reg, 1'b0});
        idx = '0;
        for (int t = 1; t < RAMP_LEN; t++)
        begin
            if (lhs >= thresh(IDX_W'(t)))
            begin
                idx = IDX_W'(t);
            end
        end
        idx_sel = cfg.invert ? IDX_W'(RAMP_LEN - 1) - idx : idx;
    end

    assign q_push          = s3_valid_reg;
    assign q_entry.glyph   = ramp_glyph(idx_sel);
    assign q_entry.row_end = s3_row_end_reg;

    `CHK_NEXT(a_credit_take, clk, rst_n, accept && !q_pop, credit_reg == $past(credit_reg) + QCNT_W'(1), "credit not taken on accept")

endmodule

`default_nettype wire

[hdl/ptag_back.sv]
// Back part: emits each glyph and, at a row end, the newline after it.
`default_nettype none
`include "assert_macros.svh"

module ptag_back
    import ptag_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_empty,
    input  wire qentry_t      q_head,
    output logic              q_pop,
    input  wire logic         pop,
    output logic              empty,
    output logic [GLYPH_W-1:0] glyph,
    output logic              last
);

    bk_state_t          state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    logic               last_reg, last_next;
    logic               load;

    assign load = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_GLYPH:
            begin
                if (load && !q_empty && q_head.row_end)
                begin
                    state_next = BK_NEWLINE;
                end
            end
            BK_NEWLINE:
            begin
                if (load)
                begin
                    state_next = BK_GLYPH;
                end
            end
            default:
            begin
                state_next = BK_GLYPH;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        glyph_next     = glyph_reg;
        last_next      = last_reg;
        case (state_reg)
            BK_GLYPH:
            begin
                if (load)
                begin
                    q_pop          = !q_empty;
                    out_valid_next = !q_empty;
                    glyph_next     = q_head.glyph;
                    last_next      = !q_head.row_end;
                end
            end
            BK_NEWLINE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    glyph_next     = NEWLINE_CODE;
                    last_next      = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_GLYPH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg <= glyph_next;
        last_reg  <= last_next;
    end

    assign empty = !out_valid_reg;
    assign glyph = glyph_reg;
    assign last  = last_reg;

    `CHK_NOW(a_nl_after_glyph, clk, rst_n, state_reg == BK_NEWLINE, out_valid_reg && !last_reg, "newline pending without its glyph")
    `CHK_NOW(a_nl_is_last, clk, rst_n, out_valid_reg && glyph_reg == NEWLINE_CODE, last_reg, "newline result not marked last")

endmodule

`default_nettype wire

[hdl/pixel_to_ascii_glyph.sv]
// Top level of the pixel to glyph converter: configuration registers and part wiring.
// An accepted pixel passes stages s1, s2 and s3, the queue and the output register.
// Throughput: one pixel per cycle while the 8-entry queue has room; the single output
// register gives one result per cycle while popped; a row-ending pixel gives two results.
// Reset (rst_n low, asynchronous) clears the row counter, queue and output; the
// registers return to invert 0, line width 80 and alpha use on.
`default_nettype none

module pixel_to_ascii_glyph
    import ptag_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Pixel requests.
    input  wire logic               push,
    output logic                    full,
    input  wire logic [CH_W-1:0]    red,
    input  wire logic [CH_W-1:0]    green,
    input  wire logic [CH_W-1:0]    blue,
    input  wire logic [CH_W-1:0]    alpha,
    // Result requests.
    output logic                    empty,
    input  wire logic               pop,
    output logic [GLYPH_W-1:0]      glyph,
    output logic                    last,
    // Register writes.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [LW_W-1:0]    cfg_data
);

    // Register file. Writes are always taken; an index past the list is dropped.
    // The user must write only while the block is idle; the block does not enforce it,
    // and the front part reads these values directly without any shadowing.
    logic            invert_reg, invert_next;
    logic [LW_W-1:0] line_width_reg, line_width_next;
    logic            use_alpha_reg, use_alpha_next;
    cfg_t            cfg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        invert_next     = invert_reg;
        line_width_next = line_width_reg;
        use_alpha_next  = use_alpha_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_INVERT:     invert_next     = cfg_data[0];
                REG_LINE_WIDTH: line_width_next = cfg_data;
                REG_USE_ALPHA:  use_alpha_next  = cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg     <= 1'b0;
            line_width_reg <= LW_W'(80);
            use_alpha_reg  <= 1'b1;
        end
        else
        begin
            invert_reg     <= invert_next;
            line_width_reg <= line_width_next;
            use_alpha_reg  <= use_alpha_next;
        end
    end

    assign cfg.invert     = invert_reg;
    assign cfg.line_width = line_width_reg;
    assign cfg.use_alpha  = use_alpha_reg;

    // The front part reserves a queue slot for every accepted pixel, so the
    // queue never overflows even with three pixels still in the arithmetic pipe.
    logic    q_push;
    logic    q_pop;
    logic    q_empty;
    qentry_t q_entry;
    qentry_t q_head;

    ptag_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .push    (push),
        .full    (full),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .alpha   (alpha),
        .q_pop   (q_pop),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    ptag_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    // The back part turns each queued pixel into one or two results and
    // holds the oldest one in its output register until it is popped.
    ptag_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .glyph   (glyph),
        .last    (last)
    );

endmodule

`default_nettype wire
